[hdl/sbv_pkg.sv]
package sbv_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned CP_W = 21;
   localparam int unsigned TAG_COUNT = 4;
   localparam int unsigned TAG_SLOTS = 16;
   localparam int unsigned SNIFF_WINDOW_DEFAULT = 1024;
   localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 32'd4194304;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last;
   } req_payload_type;

   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_TOO_LONG  = 3'd1,
      STATUS_ZERO_BYTE = 3'd2,
      STATUS_BAD_UTF8  = 3'd3,
      STATUS_HTML      = 3'd4
   } status_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] byte_total;
   } rsp_payload_type;

   // advance: the held beat is consumed this cycle; clear: it ends the stream
   typedef struct packed {
      logic advance;
      logic clear;
   } step_type;

   // "<!doctype html", "<html", "<head", "<body", zero padded
   localparam logic [BYTE_W-1:0] TAG_TEXT [TAG_COUNT][TAG_SLOTS] = '{
      '{8'h3C, 8'h21, 8'h64, 8'h6F, 8'h63, 8'h74, 8'h79, 8'h70,
        8'h65, 8'h20, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00},
      '{8'h3C, 8'h68, 8'h74, 8'h6D, 8'h6C, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h68, 8'h65, 8'h61, 8'h64, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{8'h3C, 8'h62, 8'h6F, 8'h64, 8'h79, 8'h00, 8'h00, 8'h00,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [3:0] TAG_LEN [TAG_COUNT] = '{4'd14, 4'd5, 4'd5, 4'd5};

endpackage

[hdl/sbv_utf8.sv]
module sbv_utf8 (
   input  logic                      clock,
   input  logic                      reset,
   input  sbv_pkg::step_type         step,
   input  logic [sbv_pkg::BYTE_W-1:0] data_byte,
   output logic                      broken
);
   import sbv_pkg::*;

   logic [1:0]      pend_ff, pend_in;
   logic [1:0]      seq_ff, seq_in;
   logic [CP_W-1:0] acc_ff, acc_in;
   logic            broken_ff, broken_in;
   logic [CP_W-1:0] cp;
   logic            bad;

   always_comb begin
      pend_in = pend_ff;
      seq_in  = seq_ff;
      acc_in  = acc_ff;
      bad     = 1'b0;
      cp      = {acc_ff[CP_W-7:0], data_byte[5:0]};
      if (!broken_ff) begin
         if (pend_ff == 2'd0) begin
            if (data_byte[7:5] == 3'b110) begin
               acc_in  = {16'd0, data_byte[4:0]};
               bad     = (data_byte[4:0] == 5'd0);
               pend_in = 2'd1;
               seq_in  = 2'd1;
            end else if (data_byte[7:4] == 4'b1110) begin
               acc_in  = {17'd0, data_byte[3:0]};
               pend_in = 2'd2;
               seq_in  = 2'd2;
            end else if (data_byte[7:3] == 5'b11110) begin
               acc_in  = {18'd0, data_byte[2:0]};
               pend_in = 2'd3;
               seq_in  = 2'd3;
            end else if (data_byte[7]) begin
               bad = 1'b1;
            end
         end else if (data_byte[7:6] != 2'b10) begin
            bad = 1'b1;
         end else begin
            acc_in  = cp;
            pend_in = pend_ff - 2'd1;
            if (pend_ff == 2'd1) begin
               // overlong, beyond U+10FFFF, or surrogate
               bad = (seq_ff == 2'd1 && cp < 21'h80) ||
                     (seq_ff == 2'd2 && cp < 21'h800) ||
                     (seq_ff == 2'd3 && cp < 21'h10000) ||
                     (cp > 21'h10FFFF) ||
                     (cp >= 21'h0D800 && cp <= 21'h0DFFF);
               seq_in = 2'd0;
            end
         end
         if (bad) begin
            pend_in = 2'd0;
            seq_in  = 2'd0;
            acc_in  = '0;
         end
      end
      broken_in = broken_ff | bad;
      // continuation bytes still owed count against the stream at its end
      broken = broken_in | (pend_in != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.clear)) begin
         pend_ff   <= '0;
         seq_ff    <= '0;
         acc_ff    <= '0;
         broken_ff <= 1'b0;
      end else if (step.advance) begin
         pend_ff   <= pend_in;
         seq_ff    <= seq_in;
         acc_ff    <= acc_in;
         broken_ff <= broken_in;
      end
   end

endmodule

[hdl/sbv_sniff.sv]
module sbv_sniff (
   input  logic                      clock,
   input  logic                      reset,
   input  sbv_pkg::step_type         step,
   input  logic                      enable,
   input  logic [sbv_pkg::BYTE_W-1:0] data_byte,
   output logic                      markup
);
   import sbv_pkg::*;

   typedef enum logic [2:0] {
      SNIFF_SKIP  = 3'b001,
      SNIFF_MATCH = 3'b010,
      SNIFF_DONE  = 3'b100
   } sniff_state_type;

   sniff_state_type        phase_ff, phase_in;
   logic [3:0]             mpos_ff, mpos_in, mpos_use, mpos_next;
   logic [TAG_COUNT-1:0]   cand_ff, cand_in, cand_use, keep;
   logic                   markup_ff, markup_in;
   logic [BYTE_W-1:0]      lc;
   logic                   ws, matching, hit;

   always_comb begin
      lc = (data_byte >= 8'h41 && data_byte <= 8'h5A) ? data_byte + 8'h20 : data_byte;
      ws = (lc == 8'h20) || (lc == 8'h09) || (lc == 8'h0D) || (lc == 8'h0A);

      phase_in  = phase_ff;
      mpos_in   = mpos_ff;
      cand_in   = cand_ff;
      markup_in = markup_ff;
      mpos_use  = mpos_ff;
      cand_use  = cand_ff;
      matching  = 1'b0;
      hit       = 1'b0;

      if (enable) begin
         unique case (phase_ff)
            SNIFF_SKIP: begin
               if (!ws) begin
                  matching = 1'b1;
                  mpos_use = '0;
                  cand_use = '1;
               end
            end
            SNIFF_MATCH: begin
               matching = 1'b1;
            end
            default: begin
               matching = 1'b0;
            end
         endcase
      end

      for (int k = 0; k < TAG_COUNT; k++) begin
         keep[k] = cand_use[k] && (mpos_use < TAG_LEN[k]) && (TAG_TEXT[k][mpos_use] == lc);
      end
      mpos_next = mpos_use + 4'd1;
      for (int k = 0; k < TAG_COUNT; k++) begin
         hit = hit | (keep[k] && (mpos_next == TAG_LEN[k]));
      end

      if (matching) begin
         cand_in  = keep;
         mpos_in  = mpos_next;
         phase_in = SNIFF_MATCH;
         if (hit) begin
            markup_in = 1'b1;
         end
         if (hit || keep == '0) begin
            phase_in = SNIFF_DONE;
         end
      end
      markup = markup_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step.advance && step.clear)) begin
         phase_ff  <= SNIFF_SKIP;
         mpos_ff   <= '0;
         cand_ff   <= '1;
         markup_ff <= 1'b0;
      end else if (step.advance) begin
         phase_ff  <= phase_in;
         mpos_ff   <= mpos_in;
         cand_ff   <= cand_in;
         markup_ff <= markup_in;
      end
   end

endmodule

[hdl/script_byte_validator.sv]
// Channel | Dir | Ports                              | Beat
// req     | in  | req_valid, req_ready, req_payload  | one stream byte, last flag
// rsp     | out | rsp_valid, rsp_ready, rsp_payload  | status, byte_total per stream
// csr     | in  | csr_valid, csr_ready, csr_data     | max_length write
//
// One byte per clock sustained while no held result stalls a last beat; a last
// beat's result is loaded from the input register into the result register when
// that beat advances, and is handed off from the result register.
// Reset sets max_length to 4194304 and clears all stream state.
// A held result stalls only the next last beat; other bytes keep flowing.
module script_byte_validator #(
   parameter int unsigned SNIFF_WINDOW = sbv_pkg::SNIFF_WINDOW_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  sbv_pkg::req_payload_type    req_payload,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output sbv_pkg::rsp_payload_type    rsp_payload,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [sbv_pkg::COUNT_W-1:0] csr_data
);
   import sbv_pkg::*;

   logic               in_valid_ff, in_valid_in;
   req_payload_type    in_payload_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff, rsp_payload_in;
   logic [COUNT_W-1:0] max_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               exceed_ff, exceed_in;
   logic               zero_ff, zero_in;
   logic               advance, sniff_en, utf8_broken, markup;
   step_type           step;

   assign advance = in_valid_ff && (!in_payload_ff.last || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign step.advance = advance;
   assign step.clear = in_payload_ff.last;

   // saturated counter compares as exceeding any limit
   assign count_in  = (&count_ff) ? count_ff : count_ff + 32'd1;
   assign exceed_in = exceed_ff | (count_ff >= max_ff);
   assign zero_in   = zero_ff | (in_payload_ff.data_byte == 8'h00);
   assign sniff_en  = count_ff < COUNT_W'(SNIFF_WINDOW);

   sbv_utf8 u_utf8 (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (in_payload_ff.data_byte),
      .broken    (utf8_broken)
   );

   sbv_sniff u_sniff (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .enable    (sniff_en),
      .data_byte (in_payload_ff.data_byte),
      .markup    (markup)
   );

   always_comb begin
      rsp_payload_in.byte_total = count_in;
      if (exceed_in) begin
         rsp_payload_in.status = STATUS_TOO_LONG;
      end else if (zero_in) begin
         rsp_payload_in.status = STATUS_ZERO_BYTE;
      end else if (utf8_broken) begin
         rsp_payload_in.status = STATUS_BAD_UTF8;
      end else if (markup) begin
         rsp_payload_in.status = STATUS_HTML;
      end else begin
         rsp_payload_in.status = STATUS_OK;
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (advance && in_payload_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MAX_LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            max_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (advance && in_payload_ff.last)) begin
         count_ff  <= '0;
         exceed_ff <= 1'b0;
         zero_ff   <= 1'b0;
      end else if (advance) begin
         count_ff  <= count_in;
         exceed_ff <= exceed_in;
         zero_ff   <= zero_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_payload_ff <= req_payload;
      end
      if (advance && in_payload_ff.last) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

[hdl/sbv_checker.sv]
module sbv_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input sbv_pkg::rsp_payload_type    rsp_payload,
   input logic                        csr_valid,
   input logic                        csr_ready,
   input logic [sbv_pkg::COUNT_W-1:0] csr_data
);
   import sbv_pkg::*;

   logic [COUNT_W-1:0] max_ff;

   // shadow of the length limit as seen on the csr port
   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_ff <= csr_data;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_total_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.byte_total != '0)
      else $error("result with zero byte count");

   a_too_long: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.byte_total > max_ff) |->
         rsp_payload.status == STATUS_TOO_LONG)
      else $error("overlong stream not flagged");

endmodule

bind script_byte_validator sbv_checker u_sbv_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .csr_valid   (csr_valid),
   .csr_ready   (csr_ready),
   .csr_data    (csr_data)
);

[verif/tb_top.sv]
module tb_top;
   import sbv_pkg::*;

   localparam int SNIFF_WINDOW = SNIFF_WINDOW_DEFAULT;
   localparam int DRAIN_CYCLES = 8;

   typedef enum logic [1:0] {
      SNIFF_SKIP_WS,
      SNIFF_MATCH,
      SNIFF_DONE
   } sniff_phase_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [1:0]         owed;
      logic [1:0]         seq_len;
      logic [CP_W-1:0]    cp;
      logic               too_long;
      logic               saw_zero;
      logic               bad_utf8;
      sniff_phase_type    phase;
      logic [3:0]         pos;
      logic [3:0]         cand;
      logic               is_html;
   } stream_state_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_payload_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_W-1:0] csr_data = '0;

   stream_state_type scan;
   logic [COUNT_W-1:0] length_limit;
   rsp_payload_type verdict_q[$];
   logic [7:0] stream_buf[$];
   int fail_count = 0;
   int bytes_accepted = 0;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold = 0;

   string tag_text[4] = '{"<!doctype html", "<html", "<head", "<body"};
   logic [CP_W-1:0] boundary_cp[8] = '{21'h80, 21'h7FF, 21'h800, 21'hD7FF,
                                       21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF};

   script_byte_validator #(
      .SNIFF_WINDOW(SNIFF_WINDOW)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // ---------------- verdict predictor ----------------

   function automatic void clear_scan();
      scan = '0;
      scan.phase = SNIFF_SKIP_WS;
      scan.cand = 4'hF;
   endfunction

   function automatic bit predict_verdict(input logic [7:0] b, input bit is_last,
                                          output rsp_payload_type verdict);
      logic [COUNT_W-1:0] position;
      logic [7:0] c;
      logic [3:0] keep;
      verdict = '0;
      position = scan.count;
      if (scan.count == '1) begin
         scan.too_long = 1'b1;
      end else begin
         scan.count = scan.count + 1;
         if (scan.count > length_limit) scan.too_long = 1'b1;
      end
      if (b == 8'h00) scan.saw_zero = 1'b1;

      // utf-8 decode; stops for the stream once broken
      if (!scan.bad_utf8) begin
         if (scan.owed == 2'd0) begin
            if (b[7:5] == 3'b110) begin
               scan.cp = {16'd0, b[4:0]};
               if (b[4:0] == 5'd0) scan.bad_utf8 = 1'b1;
               scan.owed = 2'd1;
               scan.seq_len = 2'd1;
            end else if (b[7:4] == 4'b1110) begin
               scan.cp = {17'd0, b[3:0]};
               scan.owed = 2'd2;
               scan.seq_len = 2'd2;
            end else if (b[7:3] == 5'b11110) begin
               scan.cp = {18'd0, b[2:0]};
               scan.owed = 2'd3;
               scan.seq_len = 2'd3;
            end else if (b[7]) begin
               scan.bad_utf8 = 1'b1;
            end
         end else if (b[7:6] != 2'b10) begin
            scan.bad_utf8 = 1'b1;
         end else begin
            scan.cp = {scan.cp[14:0], b[5:0]};
            scan.owed = scan.owed - 2'd1;
            if (scan.owed == 2'd0) begin
               if ((scan.seq_len == 2'd1 && scan.cp < 21'h80) ||
                   (scan.seq_len == 2'd2 && scan.cp < 21'h800) ||
                   (scan.seq_len == 2'd3 && scan.cp < 21'h10000) ||
                   scan.cp > 21'h10FFFF ||
                   (scan.cp >= 21'hD800 && scan.cp <= 21'hDFFF))
                  scan.bad_utf8 = 1'b1;
               scan.seq_len = 2'd0;
            end
         end
         if (scan.bad_utf8) begin
            scan.owed = 2'd0;
            scan.seq_len = 2'd0;
            scan.cp = '0;
         end
      end

      // markup sniffing inside the window
      if (position < SNIFF_WINDOW) begin
         c = b;
         if (c >= "A" && c <= "Z") c = c + 8'd32;
         if (scan.phase == SNIFF_SKIP_WS &&
             !(c == " " || c == 8'h09 || c == 8'h0D || c == 8'h0A)) begin
            scan.phase = SNIFF_MATCH;
            scan.pos = 4'd0;
            scan.cand = 4'hF;
         end
         if (scan.phase == SNIFF_MATCH) begin
            keep = 4'h0;
            for (int k = 0; k < 4; k++) begin
               if (scan.cand[k] && scan.pos < tag_text[k].len() &&
                   8'(tag_text[k][scan.pos]) == c)
                  keep[k] = 1'b1;
            end
            scan.cand = keep;
            scan.pos = scan.pos + 4'd1;
            for (int k = 0; k < 4; k++) begin
               if (keep[k] && scan.pos == tag_text[k].len()) scan.is_html = 1'b1;
            end
            if (scan.is_html || keep == 4'h0) scan.phase = SNIFF_DONE;
         end
      end

      if (!is_last) return 1'b0;

      if (scan.owed != 2'd0) scan.bad_utf8 = 1'b1;
      if (scan.too_long)
         verdict.status = STATUS_TOO_LONG;
      else if (scan.saw_zero)
         verdict.status = STATUS_ZERO_BYTE;
      else if (scan.bad_utf8)
         verdict.status = STATUS_BAD_UTF8;
      else if (scan.is_html)
         verdict.status = STATUS_HTML;
      else
         verdict.status = STATUS_OK;
      verdict.byte_total = scan.count;
      clear_scan();
      return 1'b1;
   endfunction

   // ---------------- checking ----------------

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at %0t: %s got %0d expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : check_verdicts
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_payload.status, -1);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_payload.status !== want.status)
               report_mismatch("status", rsp_payload.status, want.status);
            if (rsp_payload.byte_total !== want.byte_total)
               report_mismatch("byte_total", rsp_payload.byte_total, want.byte_total);
         end
      end
   end

   // ---------------- idling ----------------

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   always @(posedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 99) < rsp_stall_pct) rsp_hold <= pick_gap();
      end
   end

   // ---------------- driving ----------------

   task automatic send_byte(input logic [7:0] b, input bit is_last);
      rsp_payload_type verdict;
      int gap;
      req_valid <= 1'b1;
      req_payload <= {b, is_last};
      do @(posedge clock); while (!req_ready);
      bytes_accepted++;
      if (predict_verdict(b, is_last, verdict)) verdict_q.insert(verdict_q.size(), verdict);
      gap = ($urandom_range(0, 99) < send_gap_pct) ? pick_gap() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_buf.size(); i++)
         send_byte(stream_buf[i], i == stream_buf.size() - 1);
      stream_buf.delete();
   endtask

   // sender holds off until every verdict is back and the pipe has settled
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [COUNT_W-1:0] value);
      pause_until_drained();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      length_limit = value;
   endtask

   // ---------------- stream building ----------------

   function automatic void append_byte(input logic [7:0] b);
      stream_buf.insert(stream_buf.size(), b);
   endfunction

   function automatic void push_seq(input logic [CP_W-1:0] cp, input int n);
      case (n)
         1: append_byte({1'b0, cp[6:0]});
         2: begin
            append_byte({3'b110, cp[10:6]});
            append_byte({2'b10, cp[5:0]});
         end
         3: begin
            append_byte({4'b1110, cp[15:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
         default: begin
            append_byte({5'b11110, cp[20:18]});
            append_byte({2'b10, cp[17:12]});
            append_byte({2'b10, cp[11:6]});
            append_byte({2'b10, cp[5:0]});
         end
      endcase
   endfunction

   function automatic logic [CP_W-1:0] rand_cp_of_len(input int n);
      case (n)
         1: return 21'($urandom_range(0, 'h7F));
         2: return 21'($urandom_range('h80, 'h7FF));
         3: return 21'($urandom_range('h800, 'hFFFF));
         default: return 21'($urandom_range('h10000, 'h10FFFF));
      endcase
   endfunction

   // well-formed, zero-free code point
   function automatic logic [CP_W-1:0] rand_codepoint();
      logic [CP_W-1:0] cp;
      case ($urandom_range(0, 5))
         0, 1: return 21'($urandom_range(1, 'h7F));
         2: return 21'($urandom_range('h80, 'h7FF));
         3: begin
            cp = 21'($urandom_range('h800, 'hF7FF));
            if (cp >= 21'hD800) cp = cp + 21'h800;
            return cp;
         end
         4: return 21'($urandom_range('h10000, 'h10FFFF));
         default: return boundary_cp[$urandom_range(0, 7)];
      endcase
   endfunction

   function automatic void push_text(input int n);
      logic [CP_W-1:0] cp;
      repeat (n) begin
         cp = rand_codepoint();
         push_seq(cp, cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4);
      end
   endfunction

   function automatic logic [7:0] rand_ws();
      case ($urandom_range(0, 3))
         0: return 8'h20;
         1: return 8'h09;
         2: return 8'h0D;
         default: return 8'h0A;
      endcase
   endfunction

   // first cut characters of a tag, letters in random case
   function automatic void push_tag(input string t, input int cut);
      logic [7:0] ch;
      for (int i = 0; i < cut; i++) begin
         ch = 8'(t[i]);
         if (ch >= "a" && ch <= "z" && $urandom_range(0, 1) == 1) ch = ch - 8'd32;
         append_byte(ch);
      end
   endfunction

   function automatic void build_random_stream();
      int kind;
      int n;
      int cut;
      int base;
      string t;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         push_text($urandom_range(1, 10));
      end else if (kind < 65) begin
         repeat ($urandom_range(0, 3)) append_byte(rand_ws());
         t = tag_text[$urandom_range(0, 3)];
         cut = ($urandom_range(0, 3) == 0) ? $urandom_range(1, t.len() - 1) : t.len();
         base = stream_buf.size();
         push_tag(t, cut);
         if ($urandom_range(0, 5) == 0)
            stream_buf[base + $urandom_range(0, cut - 1)] ^= 8'h01;
         push_text($urandom_range(0, 6));
         if ($urandom_range(0, 5) == 0)
            append_byte($urandom_range(0, 1) ? 8'h00 : 8'hFF);
      end else if (kind < 85) begin
         push_text($urandom_range(0, 4));
         n = $urandom_range(2, 4);
         case ($urandom_range(0, 7))
            0: append_byte(8'h00);
            1: push_seq(rand_cp_of_len($urandom_range(1, n - 1)), n);   // overlong
            2: push_seq(21'($urandom_range('hD800, 'hDFFF)), 3);        // surrogate
            3: push_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);    // beyond range
            4: append_byte(8'($urandom_range('h80, 'hBF)));             // stray continuation
            5: append_byte(8'($urandom_range('hF8, 'hFF)));             // bad lead
            6: begin
               base = stream_buf.size();
               push_seq(rand_cp_of_len(n), n);
               stream_buf[base + $urandom_range(1, n - 1)] = $urandom_range(0, 1) ?
                  8'($urandom_range('h20, 'h7F)) : 8'($urandom_range('hC2, 'hF4));
            end
            default: begin
               // sequence cut off by the end of the stream
               push_seq(rand_cp_of_len(n), n);
               repeat ($urandom_range(1, n - 1)) stream_buf.delete(stream_buf.size() - 1);
               return;
            end
         endcase
         push_text($urandom_range(0, 4));
      end else begin
         repeat ($urandom_range(1, 12)) append_byte(8'($urandom_range(0, 255)));
      end
   endfunction

   task automatic run_random_streams(input int target);
      int start;
      start = bytes_accepted;
      while (bytes_accepted - start < target) begin
         build_random_stream();
         send_stream();
      end
   endtask

   // ---------------- tests ----------------

   task automatic test_directed_cases();
      send_gap_pct = 20;
      rsp_stall_pct = 20;
      stream_buf = {8'h00};
      send_stream();
      stream_buf = {8'hC0, 8'hAF};               // overlong two-byte form
      send_stream();
      stream_buf = {8'hED, 8'hA0, 8'h80};        // surrogate
      send_stream();
      stream_buf = {8'hF4, 8'h90, 8'h80, 8'h80}; // above U+10FFFF
      send_stream();
      stream_buf = {8'hE2, 8'h82};               // truncated at end
      send_stream();
      stream_buf = {8'hFF};
      send_stream();
      stream_buf = {8'h09};
      push_tag("<body", 5);
      send_stream();
      stream_buf = {8'h0A, 8'h0D, 8'h20};        // whitespace only
      send_stream();
      stream_buf = {8'h7F};
      send_stream();
   endtask

   // tag placed at the window edge: fully inside, split, or outside
   task automatic test_sniff_window();
      int start;
      send_gap_pct = 2;
      rsp_stall_pct = 5;
      start = $urandom_range(SNIFF_WINDOW - 5, SNIFF_WINDOW);
      repeat (start) append_byte(rand_ws());
      push_tag("<html", 5);
      push_text(2);
      send_stream();
   endtask

   task automatic test_length_limit(input logic [COUNT_W-1:0] limit, input int target,
                                    input int gap_pct, input int stall_pct);
      write_max_length(limit);
      send_gap_pct = gap_pct;
      rsp_stall_pct = stall_pct;
      run_random_streams(target);
   endtask

   initial begin
      clear_scan();
      length_limit = MAX_LENGTH_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_sniff_window();
      test_length_limit(32'd0, 20, 20, 20);
      test_length_limit(32'($urandom_range(1, 12)), 40, 25, 25);
      test_length_limit(32'hFFFF_FFFF, 40, 10, 10);
      test_length_limit(32'($urandom()), 20, 30, 30);
      test_length_limit(MAX_LENGTH_RESET, 40, 0, 0);   // back to back, no stalls
      test_length_limit(32'($urandom_range(5, 30)), 50, 40, 50);

      pause_until_drained();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[sim.f]
hdl/sbv_pkg.sv
hdl/sbv_utf8.sv
hdl/sbv_sniff.sv
hdl/script_byte_validator.sv
hdl/sbv_checker.sv
verif/tb_top.sv
